FILE: src/ithb_pkg.sv
// package for the immediate text to hex encoder: transaction structs, codes
// and character constants; no dependencies
package ithb_pkg;

   typedef struct packed {
      logic [7:0] token_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [7:0] hex_char;
      logic [1:0] status;
      logic       last_result;
   } rsp_type;

   // register indexes
   localparam logic CSR_ARCH_MODE  = 1'b0;
   localparam logic CSR_BIG_ENDIAN = 1'b1;

   // arch_mode codes
   localparam logic [1:0] MODE_PLAIN  = 2'd0;
   localparam logic [1:0] MODE_PREF_A = 2'd1;
   localparam logic [1:0] MODE_PREF_B = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // status codes
   localparam logic [1:0] ST_DIGIT      = 2'd0;
   localparam logic [1:0] ST_NOT_NUMBER = 2'd1;
   localparam logic [1:0] ST_RANGE      = 2'd2;
   localparam logic [1:0] ST_BAD_PREFIX = 2'd3;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7a;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5a;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_PCT   = 8'h25;

   // offsets that turn a letter into its digit value
   localparam logic [7:0] LOWER_OFS = 8'd87;
   localparam logic [7:0] UPPER_OFS = 8'd55;

endpackage

FILE: src/immediate_text_to_hex_bytes.sv
// immediate text to hex encoder, top level: parses token characters and
// emits hex digit or status results; depends on ithb_pkg
//
//   channel  direction  ports                     carries
//   req      in         req_valid/ready/data      one token character per transaction
//   rsp      out        rsp_valid/ready/data      one hex digit or status per transaction
//   csr      in         csr_we/index/wdata        arch_mode, big_endian writes
//
// a character is taken every cycle while req_ready is high; the parse state (accumulator,
// flags) updates in the same cycle through one shift-add of the 32-bit accumulator
// a token's final character hands the parsed token to the result register, which
// then emits 2, 4 or 8 digits or one status, one per cycle, limited by the rsp port
// req_ready drops only for a final character while the previous token's results are
// still going out, other than its last one being taken in that cycle
// reset (synchronous, active high) clears registers, parse state and the result valid
module immediate_text_to_hex_bytes
   import ithb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [1:0] csr_wdata
);

   // parsed token waiting for output
   typedef struct packed {
      logic [31:0] acc;
      logic        neg;
      logic        bad;
      logic        first_zero;
      logic [7:0]  prefix;
      logic [1:0]  mode;
      logic        big_end;
   } token_type;

   // configuration
   logic [1:0]  arch_mode_ff;
   logic        big_endian_ff;

   // parse state
   logic [1:0]  char_pos_ff, char_pos_in;
   logic [7:0]  prefix_ff, prefix_in;
   logic [7:0]  first_ff, first_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        hex_ff, hex_in;
   logic        bad_ff, bad_in;

   // result register
   logic        emit_valid_ff, emit_valid_in;
   logic [2:0]  emit_idx_ff, emit_idx_in;
   token_type   emit_tok_ff, emit_tok_in;

   logic        req_fire, rsp_fire;
   logic        prefixed;
   logic [1:0]  stage;
   logic [7:0]  ch;
   logic        dig_ok;
   logic [7:0]  dig_val;
   logic [31:0] acc_digit;

   assign ch       = req_data.token_char;
   assign prefixed = (arch_mode_ff == MODE_PREF_A) || (arch_mode_ff == MODE_PREF_B);

   // ---------------------------------------------------------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         arch_mode_ff  <= MODE_PLAIN;
         big_endian_ff <= 1'b0;
      end else if (csr_we) begin
         if (csr_index == CSR_ARCH_MODE) arch_mode_ff <= csr_wdata;
         else big_endian_ff <= csr_wdata[0];
      end
   end

   // ---------------------------------------------------------------- digit decode
   always_comb begin
      dig_ok  = 1'b1;
      dig_val = 8'd0;
      if (ch >= CH_ZERO && ch <= CH_NINE) begin
         dig_val = ch - CH_ZERO;
      end else if (hex_ff && ch >= CH_LA && ch <= CH_LZ) begin
         dig_val = ch - LOWER_OFS;
      end else if (hex_ff && ch >= CH_UA && ch <= CH_UZ) begin
         dig_val = ch - UPPER_OFS;
      end else begin
         dig_ok = 1'b0;
      end
      // letters give up to 35, so the digit is not masked to four bits
      if (hex_ff) acc_digit = {acc_ff[27:0], 4'd0} + {24'd0, dig_val};
      else acc_digit = {acc_ff[28:0], 3'd0} + {acc_ff[30:0], 1'b0} + {24'd0, dig_val};
   end

   // stage within the digit string: first digit, possible 'x', the rest
   always_comb begin
      if (prefixed) stage = char_pos_ff - 2'd1;
      else stage = (char_pos_ff >= 2'd2) ? 2'd2 : char_pos_ff;
   end

   // ---------------------------------------------------------------- parse step
   always_comb begin
      char_pos_in = char_pos_ff;
      prefix_in   = prefix_ff;
      first_in    = first_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      hex_in      = hex_ff;
      bad_in      = bad_ff;

      if (prefixed && char_pos_ff == 2'd0) begin
         prefix_in = ch;
      end else if (stage == 2'd0) begin
         first_in = ch;
         if (ch == CH_MINUS) neg_in = 1'b1;
         else if (dig_ok) acc_in = acc_digit;
         else bad_in = 1'b1;
      end else if (stage == 2'd1 && first_ff == CH_ZERO && ch == CH_LX) begin
         hex_in = 1'b1;
         acc_in = 32'd0;
      end else begin
         if (dig_ok) acc_in = acc_digit;
         else bad_in = 1'b1;
      end
      if (char_pos_ff != 2'd3) char_pos_in = char_pos_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_pos_ff <= 2'd0;
         prefix_ff   <= 8'd0;
         first_ff    <= 8'd0;
         acc_ff      <= 32'd0;
         neg_ff      <= 1'b0;
         hex_ff      <= 1'b0;
         bad_ff      <= 1'b0;
      end else if (req_fire) begin
         if (req_data.last_char) begin
            // token done: fresh state for the next one
            char_pos_ff <= 2'd0;
            prefix_ff   <= 8'd0;
            first_ff    <= 8'd0;
            acc_ff      <= 32'd0;
            neg_ff      <= 1'b0;
            hex_ff      <= 1'b0;
            bad_ff      <= 1'b0;
         end else begin
            char_pos_ff <= char_pos_in;
            prefix_ff   <= prefix_in;
            first_ff    <= first_in;
            acc_ff      <= acc_in;
            neg_ff      <= neg_in;
            hex_ff      <= hex_in;
            bad_ff      <= bad_in;
         end
      end
   end

   // ---------------------------------------------------------------- result side
   logic [31:0] value;
   logic [31:0] val_b, val_w;
   logic        is_num;
   logic [1:0]  status;
   logic [3:0]  n_res;
   logic        msb_first, lower;
   logic [2:0]  nib_idx;
   logic [3:0]  nib;
   logic [7:0]  hex_ch;
   logic        rsp_last;

   always_comb begin
      value  = emit_tok_ff.bad ? 32'd0 : (emit_tok_ff.neg ? (32'd0 - emit_tok_ff.acc)
                                                          : emit_tok_ff.acc);
      is_num = emit_tok_ff.first_zero || (value != 32'd0);
      val_b  = value + 32'd128;
      val_w  = value + 32'd32768;
      status    = ST_DIGIT;
      n_res     = 4'd4;
      msb_first = 1'b1;
      lower     = 1'b0;
      if (emit_tok_ff.mode == MODE_UNUSED || !is_num) begin
         status = ST_NOT_NUMBER;
      end else if (emit_tok_ff.mode == MODE_PLAIN) begin
         if (val_w[31:16] != 16'd0) status = ST_RANGE;
      end else begin
         msb_first = emit_tok_ff.big_end;
         lower     = emit_tok_ff.big_end;
         case (emit_tok_ff.prefix)
            CH_BANG: begin
               n_res = 4'd2;
               if (val_b[31:8] != 24'd0) status = ST_RANGE;
            end
            CH_AT: begin
               n_res = 4'd4;
               if (val_w[31:16] != 16'd0) status = ST_RANGE;
            end
            CH_PCT: begin
               n_res = 4'd8;
            end
            default: begin
               status = ST_BAD_PREFIX;
            end
         endcase
      end

      // little-endian order walks bytes upward, high nibble first
      if (msb_first) nib_idx = 3'(n_res - 4'd1 - {1'b0, emit_idx_ff});
      else nib_idx = {emit_idx_ff[2:1], ~emit_idx_ff[0]};
      nib = 4'(value >> {nib_idx, 2'b00});
      if (nib < 4'd10) hex_ch = CH_ZERO + {4'd0, nib};
      else hex_ch = (lower ? CH_LA : CH_UA) + {4'd0, nib} - 8'd10;

      rsp_last = (status != ST_DIGIT) || ({1'b0, emit_idx_ff} == n_res - 4'd1);

      rsp_data.hex_char    = (status == ST_DIGIT) ? hex_ch : 8'd0;
      rsp_data.status      = status;
      rsp_data.last_result = rsp_last;
   end

   assign rsp_valid = emit_valid_ff;
   assign rsp_fire  = rsp_valid && rsp_ready;
   // a final character needs the result register free by the end of this cycle
   assign req_ready = !emit_valid_ff || !req_data.last_char || (rsp_ready && rsp_last);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      emit_valid_in = emit_valid_ff;
      emit_idx_in   = emit_idx_ff;
      emit_tok_in   = emit_tok_ff;
      if (rsp_fire) begin
         if (rsp_last) emit_valid_in = 1'b0;
         else emit_idx_in = emit_idx_ff + 3'd1;
      end
      if (req_fire && req_data.last_char) begin
         emit_valid_in          = 1'b1;
         emit_idx_in            = 3'd0;
         emit_tok_in.acc        = acc_in;
         emit_tok_in.neg        = neg_in;
         emit_tok_in.bad        = bad_in;
         emit_tok_in.first_zero = (first_in == CH_ZERO);
         emit_tok_in.prefix     = prefix_in;
         emit_tok_in.mode       = arch_mode_ff;
         emit_tok_in.big_end    = big_endian_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_valid_ff <= 1'b0;
         emit_idx_ff   <= 3'd0;
      end else begin
         emit_valid_ff <= emit_valid_in;
         emit_idx_ff   <= emit_idx_in;
      end
      emit_tok_ff <= emit_tok_in;
   end

endmodule

FILE: dv/immediate_text_to_hex_bytes_checker.sv
`timescale 1ns / 1ps
// checker for the immediate text to hex encoder: watches req, rsp and csr, predicts
// the digit and status results of each token and compares them; depends on ithb_pkg
module immediate_text_to_hex_bytes_checker
   import ithb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [1:0] csr_wdata,
   output int         mismatch_count,
   output int         pending_count
);

   // mirrored registers
   logic [1:0]  mode_reg;
   logic        be_reg;

   // token parse state
   logic [1:0]  seen_count;
   logic [7:0]  width_sym;
   logic [7:0]  lead_char;
   logic [31:0] acc;
   logic        neg;
   logic        in_hex;
   logic        bad;

   rsp_type     expected_hex[$];
   int          errors = 0;
   int          queued = 0;

   assign mismatch_count = errors;
   assign pending_count  = queued;

   task automatic flag_error(input string msg);
      $display("%0t mismatch: %s", $time, msg);
      errors++;
   endtask

   task automatic clear_token();
      seen_count = 2'd0;
      width_sym  = 8'd0;
      lead_char  = 8'd0;
      acc        = 32'd0;
      neg        = 1'b0;
      in_hex     = 1'b0;
      bad        = 1'b0;
   endtask

   task automatic absorb_digit(input logic [7:0] c);
      logic [31:0] d;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = {24'd0, c - CH_ZERO};
      end else if (in_hex && c >= CH_LA && c <= CH_LZ) begin
         d = {24'd0, c - LOWER_OFS};
      end else if (in_hex && c >= CH_UA && c <= CH_UZ) begin
         d = {24'd0, c - UPPER_OFS};
      end else begin
         bad = 1'b1;
         return;
      end
      acc = in_hex ? acc * 32'd16 + d : acc * 32'd10 + d;
   endtask

   task automatic push_status(input logic [1:0] st);
      rsp_type item;
      item = '{hex_char: 8'd0, status: st, last_result: 1'b1};
      expected_hex.push_back(item);
   endtask

   task automatic encode_token();
      logic [31:0] value;
      logic        is_num;
      logic        msb_first;
      logic        lowercase;
      logic [3:0]  nib;
      int          nbytes;
      int          ndig;
      int          pos;
      rsp_type     item;
      value  = bad ? 32'd0 : (neg ? 32'd0 - acc : acc);
      is_num = (lead_char == CH_ZERO) || (value != 32'd0);
      if (mode_reg == MODE_UNUSED || !is_num) begin
         push_status(ST_NOT_NUMBER);
         return;
      end
      if (mode_reg == MODE_PLAIN) begin
         nbytes    = 2;
         msb_first = 1'b1;
         lowercase = 1'b0;
      end else begin
         case (width_sym)
            CH_BANG: nbytes = 1;
            CH_AT:   nbytes = 2;
            CH_PCT:  nbytes = 4;
            default: begin
               push_status(ST_BAD_PREFIX);
               return;
            end
         endcase
         msb_first = be_reg;
         lowercase = be_reg;
      end
      if ((nbytes == 1 && (value + 32'd128) > 32'd255) ||
          (nbytes == 2 && (value + 32'd32768) > 32'd65535)) begin
         push_status(ST_RANGE);
         return;
      end
      ndig = nbytes * 2;
      for (int i = 0; i < ndig; i++) begin
         if (msb_first) pos = ndig - 1 - i;
         else pos = (i / 2) * 2 + ((i % 2 == 1) ? 0 : 1);
         nib = value[pos * 4 +: 4];
         if (nib < 4'd10) item.hex_char = CH_ZERO + {4'd0, nib};
         else if (lowercase) item.hex_char = LOWER_OFS + {4'd0, nib};
         else item.hex_char = UPPER_OFS + {4'd0, nib};
         item.status      = ST_DIGIT;
         item.last_result = (i == ndig - 1);
         expected_hex.push_back(item);
      end
   endtask

   task automatic parse_char(input req_type r);
      logic       prefixed;
      logic [1:0] stage;
      prefixed = (mode_reg == MODE_PREF_A || mode_reg == MODE_PREF_B);
      if (prefixed && seen_count == 2'd0) begin
         width_sym = r.token_char;
      end else begin
         if (prefixed) stage = seen_count - 2'd1;
         else stage = (seen_count >= 2'd2) ? 2'd2 : seen_count;
         if (stage == 2'd0) begin
            lead_char = r.token_char;
            if (r.token_char == CH_MINUS) neg = 1'b1;
            else absorb_digit(r.token_char);
         end else if (stage == 2'd1 && lead_char == CH_ZERO && r.token_char == CH_LX) begin
            in_hex = 1'b1;
            acc    = 32'd0;
         end else begin
            absorb_digit(r.token_char);
         end
      end
      if (seen_count != 2'd3) seen_count++;
      if (r.last_char) begin
         encode_token();
         clear_token();
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_hex.size() == 0) begin
         flag_error($sformatf("unexpected result char %h status %0d last %b",
                              got.hex_char, got.status, got.last_result));
         return;
      end
      want = expected_hex.pop_front();
      if (got.hex_char !== want.hex_char)
         flag_error($sformatf("hex_char %h, expected %h", got.hex_char, want.hex_char));
      if (got.status !== want.status)
         flag_error($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.last_result !== want.last_result)
         flag_error($sformatf("last_result %b, expected %b",
                              got.last_result, want.last_result));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_reg = MODE_PLAIN;
         be_reg   = 1'b0;
         clear_token();
         expected_hex.delete();
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) parse_char(req_data);
         if (csr_we) begin
            if (csr_index == CSR_ARCH_MODE) mode_reg = csr_wdata;
            else be_reg = csr_wdata[0];
         end
      end
      queued = expected_hex.size();
   end

endmodule

FILE: dv/immediate_text_to_hex_bytes_tb.sv
`timescale 1ns / 1ps
// testbench top for the immediate text to hex encoder: drives token characters and
// csr writes, idles both channels and gives the verdict; depends on ithb_pkg, the block
// and immediate_text_to_hex_bytes_checker
module immediate_text_to_hex_bytes_tb;
   import ithb_pkg::*;

   // cycles with no transaction and no csr write before the run is called hung
   localparam int QUIET_LIMIT   = 1000;
   // a final character is handed to the result register as it is taken, so the settle
   // time below is plenty for the block
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_CHARS   = 20;
   localparam int NUM_PHASES    = 8;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_ready;
   rsp_type    rsp_data;
   logic       csr_we;
   logic       csr_index;
   logic [1:0] csr_wdata;

   int         mismatches;
   int         pending;
   int         gap_pct      = 0;
   int         stall_pct    = 0;
   int         quiet_cycles = 0;
   int         phase_chars  = 0;
   logic [1:0] cur_mode;
   logic [7:0] token_buf[$];

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   immediate_text_to_hex_bytes DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   immediate_text_to_hex_bytes_checker hex_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatches),
      .pending_count  (pending)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(9) == 0) return $urandom_range(40, 12);
      return $urandom_range(3, 1);
   endfunction

   // watchdog: any transaction or csr write restarts the count
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stalls, none while stall_pct is zero
   initial begin
      int hold;
      hold      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(99) < stall_pct) hold = pick_gap();
         end
      end
   end

   // all driving tasks start and end on a falling edge

   // one character transaction; valid only drops when a gap is taken
   task automatic send_char(input logic [7:0] c, input logic last);
      int gap;
      gap = ($urandom_range(99) < gap_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{token_char: c, last_char: last};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      phase_chars++;
   endtask

   task automatic hold_req();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   // sender stops until every expected result has come out
   task automatic drain_results();
      hold_req();
      while (pending != 0) @(negedge clock);
   endtask

   // block fully idle, safe for a register write
   task automatic quiesce();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // the extra edge keeps csr_we from being lowered and raised in one step
   task automatic write_reg(input logic idx, input logic [1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_ARCH_MODE) cur_mode = val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [1:0] mode, input logic be);
      write_reg(CSR_ARCH_MODE, mode);
      write_reg(CSR_BIG_ENDIAN, {1'b0, be});
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) token_buf.push_back(s[i]);
   endtask

   // whole token from the buffer, last_char on its final character
   task automatic send_token();
      for (int i = 0; i < token_buf.size(); i++)
         send_char(token_buf[i], i == token_buf.size() - 1);
      token_buf.delete();
   endtask

   task automatic send_text(input string s);
      load_text(s);
      send_token();
   endtask

   // random token: mostly well formed numbers near the range edges, some raw noise,
   // some with a broken prefix, a stray character or no digits
   task automatic build_random_token();
      longint      val;
      logic [31:0] bits;
      string       digs;
      string       txt;
      int          pick;
      token_buf.delete();
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(4, 1)) token_buf.push_back(8'($urandom_range(255)));
         return;
      end
      if (cur_mode == MODE_PREF_A || cur_mode == MODE_PREF_B) begin
         pick = $urandom_range(19);
         if (pick < 6) token_buf.push_back(CH_BANG);
         else if (pick < 12) token_buf.push_back(CH_AT);
         else if (pick < 18) token_buf.push_back(CH_PCT);
         else if (pick == 18) token_buf.push_back(8'($urandom_range(255)));
         // otherwise no prefix at all, the first digit takes its place
      end
      case ($urandom_range(13))
         0:       val = 127;
         1:       val = 128;
         2:       val = -128;
         3:       val = -129;
         4:       val = 32767;
         5:       val = 32768;
         6:       val = -32768;
         7:       val = -32769;
         8:       val = 0;
         9:       val = longint'($urandom_range(255)) - 128;
         10:      val = longint'($urandom) - 64'sd2147483648;
         11:      val = longint'($urandom) * 3;  // past 2^32, wraps
         default: val = $urandom_range(999);
      endcase
      if ($urandom_range(3) == 0) begin
         // hex form, case of the digits at random, sometimes letters past f
         bits = val[31:0];
         digs = $sformatf("%0h", bits);
         if ($urandom_range(1) == 0) digs = digs.toupper();
         if ($urandom_range(7) == 0) digs[$urandom_range(digs.len() - 1)] =
            byte'($urandom_range(122, 103));
         if ($urandom_range(15) == 0) digs = "";
         txt = {"0x", digs};
      end else begin
         txt = $sformatf("%0d", val);
         pick = $urandom_range(15);
         if (pick == 0) txt = "-";
         else if (pick == 1) txt = "";
      end
      load_text(txt);
      if (token_buf.size() > 0 && $urandom_range(15) == 0)
         token_buf[$urandom_range(token_buf.size() - 1)] = 8'($urandom_range(255));
      if (token_buf.size() == 0) token_buf.push_back(CH_ZERO);
   endtask

   // main stimulus
   initial begin
      logic paused;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_ARCH_MODE;
      csr_wdata = MODE_PLAIN;
      cur_mode  = MODE_PLAIN;
      paused    = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: plain mode, big endian uppercase always
      set_config(MODE_PLAIN, 1'b0);
      send_text("0");
      send_text("-1");        // two's complement, no sign extension
      send_text("-");         // lone minus is not a number
      send_text("32768");     // just over the 2 byte range
      send_text("0xZ");       // letters count as written, Z is 35

      // prefixed, little endian uppercase
      quiesce();
      set_config(MODE_PREF_A, 1'b0);
      send_text("!-128");
      send_text("!128");
      send_text("!");         // prefix only, empty digit string
      send_text("%0x");       // bare 0x is the number zero
      send_text("#5");        // bad prefix
      send_text("@z");        // bad digit, no leading zero

      // prefixed, big endian lowercase
      quiesce();
      set_config(MODE_PREF_B, 1'b1);
      send_text("%-1");
      send_text("@0 ");       // space is a bad digit, leading zero keeps it a number
      load_text("!0x");
      token_buf.push_back(8'h00);
      send_token();           // zero byte as a digit
      token_buf.push_back(8'h00);
      load_text("5");
      send_token();           // zero byte as the prefix
      send_text("%4294967296");  // wraps to zero
      send_text("@-32768");
      send_text("!-");

      // unused mode always reports not a number
      quiesce();
      set_config(MODE_UNUSED, 1'b1);
      send_text("12");

      // mode switched in the middle of a token
      quiesce();
      set_config(MODE_PREF_A, 1'b0);
      send_char(CH_PCT, 1'b0);
      hold_req();
      write_reg(CSR_ARCH_MODE, MODE_PLAIN);
      send_char(CH_ZERO + 8'd5, 1'b1);

      // random phases, each one writing its register setting and choosing an idle mix
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         quiesce();
         case (phase)
            0:       set_config(MODE_PLAIN, 1'b0);
            1:       set_config(MODE_PREF_A, 1'b0);
            2:       set_config(MODE_PREF_B, 1'b1);
            3:       set_config(MODE_UNUSED, 1'b0);
            4:       set_config(MODE_PREF_A, 1'b1);
            default: set_config(2'($urandom_range(3)), 1'($urandom_range(1)));
         endcase
         // back to back stretches in some phases, heavy idling in the last
         if (phase == 0 || phase == 4) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else if (phase == NUM_PHASES - 1) begin
            gap_pct   = 60;
            stall_pct = 60;
         end else begin
            gap_pct   = 25;
            stall_pct = 25;
         end
         phase_chars = 0;
         while (phase_chars < PHASE_CHARS) begin
            // sender waits once mid-phase for the result side to run dry
            if (phase == 2 && !paused && phase_chars >= PHASE_CHARS / 2) begin
               drain_results();
               paused = 1'b1;
            end
            build_random_token();
            send_token();
         end
      end

      // end of run: everything out, then a short settle
      drain_results();
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      if (mismatches == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule
